[sv/pdq_pkg.sv]
package pdq_pkg;

    // Store geometry.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Derived widths: slot index, word count, and a compare width wide enough
    // for both the count and the 8-bit position field.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = 8;
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Field widths on the stream ports.
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int OCNT_W = 5;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;  // capture the incoming word
        logic exec;  // apply the command and load the result register
    } t_dp_cmd;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // Fit a stored word into a 32-bit output field.
    function automatic logic [VAL_W-1:0] to_out(input t_word w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[VAL_W-1:0];
    endfunction

    // Keep the low DATA_WIDTH bits of an incoming 32-bit value.
    function automatic t_word to_word(input logic [VAL_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[DATA_WIDTH-1:0];
    endfunction

endpackage

[sv/pdq_ctrl.sv]
module pdq_ctrl import pdq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   exec_ok;

    // The result register is free when empty or being taken this cycle.
    assign exec_ok = !r_out_valid || i_m_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_EXEC: begin
                o_cmd.exec = exec_ok;
            end
            default: ;
        endcase
    end

    // Result valid is set by an execute and cleared when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

[sv/pdq_datapath.sv]
module pdq_datapath import pdq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [VAL_W-1:0]    i_value,
    input  logic [POS_W-1:0]    i_position,
    output logic [VAL_W-1:0]    o_popped_value,
    output logic [VAL_W-1:0]    o_front_value,
    output logic [VAL_W-1:0]    o_back_value,
    output logic [OCNT_W-1:0]   o_entry_count,
    output logic                o_is_empty,
    output logic [STAT_W-1:0]   o_status
);

    // Captured command.
    t_cmd             r_cmd;
    t_word            r_word;
    logic [POS_W-1:0] r_pos;

    // Slot row, slot 0 is the front, and the word count.
    t_word            r_slot [CAPACITY];
    t_word            n_slot [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register.
    logic [VAL_W-1:0]  r_popped;
    logic [VAL_W-1:0]  r_front;
    logic [VAL_W-1:0]  r_back;
    logic [OCNT_W-1:0] r_ocount;
    logic              r_empty;
    t_status           r_status;

    logic              full;
    logic              empty;
    logic              pos_past;
    logic              do_insert;
    logic [IDX_W-1:0]  ins_idx;
    logic [IDX_W-1:0]  back_idx;
    logic [CNT_W-1:0]  count_m1;
    t_word             popped;
    t_status           status;
    logic [63:0]       count_wide;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_past = (CMP_W'(r_pos) >= CMP_W'(r_count));
    assign count_m1 = r_count - CNT_W'(1);

    // Insert slot: front, back, or the given position capped at the count.
    always_comb begin
        if (r_cmd == CMD_PUSH_FRONT) begin
            ins_idx = '0;
        end else if (r_cmd == CMD_PUSH_BACK || pos_past) begin
            ins_idx = r_count[IDX_W-1:0];
        end else begin
            ins_idx = r_pos[IDX_W-1:0];
        end
    end

    // Command decode and slot row update.
    always_comb begin
        n_slot    = r_slot;
        n_count   = r_count;
        popped    = '0;
        status    = STAT_OK;
        do_insert = 1'b0;
        unique case (r_cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status = STAT_EMPTY;
                end else begin
                    popped  = r_slot[0];
                    n_count = count_m1;
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_slot[i] = r_slot[i+1];
                    end
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    status = STAT_EMPTY;
                end else begin
                    popped  = r_slot[count_m1[IDX_W-1:0]];
                    n_count = count_m1;
                end
            end
            default: ;
        endcase
        // Cells above the insert slot take their lower neighbor.
        if (do_insert) begin
            for (int i = 1; i < CAPACITY; i++) begin
                if (IDX_W'(i) > ins_idx) begin
                    n_slot[i] = r_slot[i-1];
                end
            end
            n_slot[ins_idx] = r_word;
        end
    end

    assign back_idx   = IDX_W'(n_count - CNT_W'(1));
    assign count_wide = 64'(n_count);

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_word <= to_word(i_value);
            r_pos  <= i_position;
        end
    end

    // Slot row and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_slot   <= n_slot;
            r_popped <= to_out(popped);
            r_front  <= (n_count == '0) ? '0 : to_out(n_slot[0]);
            r_back   <= (n_count == '0) ? '0 : to_out(n_slot[back_idx]);
            r_ocount <= count_wide[OCNT_W-1:0];
            r_empty  <= (n_count == '0);
            r_status <= status;
        end
    end

    // Word count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_popped_value = r_popped;
    assign o_front_value  = r_front;
    assign o_back_value   = r_back;
    assign o_entry_count  = r_ocount;
    assign o_is_empty     = r_empty;
    assign o_status       = r_status;

endmodule

[sv/positional_deque_store_core.sv]
// Channel  Dir  Handshake            Payload
// s        in   i_s_tvalid/o_s_tready  i_s_tdata: command, value, position
// m        out  o_m_tvalid/i_m_tready  o_m_tdata: popped, front, back, count,
//                                      empty flag, status
//
// Each command word is first captured, then run through the slot row,
// which shifts all cells at once for insert and pop.
// The result register lets the next word be captured while a result waits;
// the execute cycle stalls while the result register is still full.
// Reset clears the word count and the controller state; slot contents need no clearing.
module positional_deque_store_core import pdq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // command[2:0], value[34:3], position[42:35]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata    // popped_value[31:0], front_value[63:32],
                                      // back_value[95:64], entry_count[100:96],
                                      // is_empty[101], status[103:102]
);

    t_dp_cmd           cmd;
    logic [VAL_W-1:0]  popped_value;
    logic [VAL_W-1:0]  front_value;
    logic [VAL_W-1:0]  back_value;
    logic [OCNT_W-1:0] entry_count;
    logic              is_empty;
    logic [STAT_W-1:0] status;

    pdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    pdq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_s_tdata[2:0]),
        .i_value        (i_s_tdata[34:3]),
        .i_position     (i_s_tdata[42:35]),
        .o_popped_value (popped_value),
        .o_front_value  (front_value),
        .o_back_value   (back_value),
        .o_entry_count  (entry_count),
        .o_is_empty     (is_empty),
        .o_status       (status)
    );

    assign o_m_tdata = {status, is_empty, entry_count, back_value, front_value, popped_value};

    // A captured word is never followed by another capture in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a command is still pending");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // A refused push only happens on a full store.
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == STAT_FULL) |-> ({27'd0, entry_count} == CAPACITY))
        else $error("push refused while store not full");

    // A refused pop only happens on an empty store.
    a_empty_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == STAT_EMPTY) |-> (is_empty && popped_value == '0))
        else $error("pop refused while store not empty");

endmodule
